FILE: hdl/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and constants for the ordered list block: list capacity,
// derived widths, request and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package olid_pkg;

	// list capacity, 2 .. 64
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LEN_W    = $clog2(CAPACITY + 1);

	// port field widths
	localparam int REQ_W    = 3;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 8;
	localparam int STAT_W   = 2;
	localparam int EIDX_W   = 6;
	localparam int OLEN_W   = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_LAST  = 3'd0,
		REQ_ADD_FIRST = 3'd1,
		REQ_ADD_POS   = 3'd2,
		REQ_DEL_LAST  = 3'd3,
		REQ_DEL_FIRST = 3'd4,
		REQ_DEL_POS   = 3'd5,
		REQ_DUMP      = 3'd6
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_OOB   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// what the held request turns out to be
	typedef enum logic [1:0] {
		OPK_NONE,
		OPK_CHANGE,
		OPK_DUMP
	} op_kind_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture the request, clear the dump index
		logic commit;  // apply insert/delete, load the single result
		logic emit;    // load one dump result, advance the index
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_kind_t kind;
		logic     len_zero;
		logic     idx_last;
	} dp_stat_t;

endpackage

FILE: hdl/olid_ctrl.sv
// ----------------------------------------------------------------------------
// olid_ctrl
// Request sequencer: accepts a request, runs it through the datapath and
// paces results against the output handshake. Owns the output valid flag.
// ----------------------------------------------------------------------------
module olid_ctrl import olid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	// output register can take a new result this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_EXEC: begin
				if (slot_free) begin
					if (stat.kind == OPK_CHANGE || (stat.kind == OPK_DUMP && stat.len_zero)) begin
						cmd.commit = 1'b1;
					end else if (stat.kind == OPK_DUMP) begin
						cmd.emit = 1'b1;
					end
				end
			end
			S_DUMP: begin
				cmd.emit = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.kind == OPK_NONE) begin
						state_q <= S_IDLE;
					end else if (cmd.commit) begin
						state_q <= S_IDLE;
					end else if (cmd.emit) begin
						state_q <= stat.idx_last ? S_IDLE : S_DUMP;
					end
				end
				S_DUMP: begin
					if (cmd.emit && stat.idx_last) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// one result source per cycle
	a_one_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.emit))
		else $error("commit and emit in the same cycle");

	// never overwrite a result that is still waiting
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.emit) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	// an accepted request moves the sequencer to the execute state in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted request not executed");

endmodule

FILE: hdl/olid_dpath.sv
// ----------------------------------------------------------------------------
// olid_dpath
// List storage and result path: request register, a row of entry
// registers that all shift by one place in the same cycle, length and dump index
// counters, request decode and the output result register.
// ----------------------------------------------------------------------------
module olid_dpath import olid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [VAL_W-1:0]  value,
	input  logic [POS_W-1:0]         position,
	output logic [STAT_W-1:0]        status,
	output logic signed [VAL_W-1:0]  element,
	output logic [EIDX_W-1:0]        element_index,
	output logic [OLEN_W-1:0]        length,
	output logic                     last_of_run
);

	// held request
	req_t                   req_q;
	logic signed [VAL_W-1:0] value_q;
	logic [POS_W-1:0]       pos_q;

	// list state
	logic signed [VAL_W-1:0] store_q [CAPACITY];
	logic signed [VAL_W-1:0] store_d [CAPACITY];
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       len_d;
	logic [IDX_W-1:0]       idx_q;

	// result register
	status_t                status_q;
	logic signed [VAL_W-1:0] element_q;
	logic [EIDX_W-1:0]      eidx_q;
	logic [OLEN_W-1:0]      length_q;
	logic                   last_q;

	// decode
	op_kind_t               dec_kind;
	status_t                dec_st;
	logic                   dec_ins;
	logic [IDX_W-1:0]       dec_at;
	logic                   dec_ok;
	logic                   len_zero;
	logic                   len_full;
	logic                   idx_last;
	logic [POS_W:0]         pos_x;
	logic [POS_W:0]         len_x;
	logic                   apply;

	assign len_zero = (len_q == '0);
	assign len_full = (len_q == LEN_W'(CAPACITY));
	assign idx_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);
	assign pos_x    = {1'b0, pos_q};
	assign len_x    = (POS_W+1)'(len_q);

	always_comb begin
		dec_kind = OPK_NONE;
		dec_st   = ST_OK;
		dec_ins  = 1'b0;
		dec_at   = '0;
		unique case (req_q) inside
			REQ_ADD_LAST, REQ_ADD_FIRST, REQ_ADD_POS: begin
				dec_kind = OPK_CHANGE;
				dec_ins  = 1'b1;
				if (len_full) begin
					dec_st = ST_FULL;
				end else if (req_q == REQ_ADD_LAST) begin
					dec_at = IDX_W'(len_q);
				end else if (req_q == REQ_ADD_FIRST || len_zero || pos_q <= POS_W'(1)) begin
					dec_at = '0;
				end else if (pos_x <= len_x + (POS_W+1)'(1)) begin
					dec_at = IDX_W'(pos_q - POS_W'(1));
				end else begin
					dec_st = ST_OOB;
				end
			end
			REQ_DEL_LAST, REQ_DEL_FIRST, REQ_DEL_POS: begin
				dec_kind = OPK_CHANGE;
				if (len_zero) begin
					dec_st = ST_EMPTY;
				end else if (req_q == REQ_DEL_LAST) begin
					dec_at = IDX_W'(len_q - LEN_W'(1));
				end else if (req_q == REQ_DEL_FIRST || pos_q <= POS_W'(1)) begin
					dec_at = '0;
				end else if (pos_x <= len_x) begin
					dec_at = IDX_W'(pos_q - POS_W'(1));
				end else begin
					dec_st = ST_OOB;
				end
			end
			REQ_DUMP: begin
				// only committed when the list is empty
				dec_kind = OPK_DUMP;
				dec_st   = ST_EMPTY;
			end
			default: begin
				dec_kind = OPK_NONE;
			end
		endcase
	end

	assign dec_ok = (dec_st == ST_OK);
	assign apply  = cmd.commit && dec_ok && (dec_kind == OPK_CHANGE);

	assign stat.kind     = dec_kind;
	assign stat.len_zero = len_zero;
	assign stat.idx_last = idx_last;

	// next entries: every entry looks only at its neighbors and the held value
	always_comb begin
		store_d = store_q;
		len_d   = len_q;
		if (apply) begin
			if (dec_ins) begin
				for (int k = 1; k < CAPACITY; k++) begin
					if (LEN_W'(k) > LEN_W'(dec_at) && LEN_W'(k) <= len_q) begin
						store_d[k] = store_q[k-1];
					end
				end
				store_d[dec_at] = value_q;
				len_d = len_q + LEN_W'(1);
			end else begin
				for (int k = 0; k < CAPACITY - 1; k++) begin
					if (LEN_W'(k) >= LEN_W'(dec_at) && (LEN_W'(k) + LEN_W'(1)) < len_q) begin
						store_d[k] = store_q[k+1];
					end
				end
				len_d = len_q - LEN_W'(1);
			end
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
		end else begin
			len_q <= len_d;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		store_q <= store_d;
		if (cmd.load) begin
			req_q   <= req_t'(req_type);
			value_q <= value;
			pos_q   <= position;
		end
		if (cmd.commit) begin
			status_q  <= dec_st;
			element_q <= '0;
			eidx_q    <= '0;
			length_q  <= OLEN_W'(len_d);
			last_q    <= 1'b1;
		end else if (cmd.emit) begin
			status_q  <= ST_OK;
			element_q <= store_q[idx_q];
			eidx_q    <= EIDX_W'(idx_q);
			length_q  <= OLEN_W'(len_q);
			last_q    <= idx_last;
		end
	end

	assign status        = status_q;
	assign element       = element_q;
	assign element_index = eidx_q;
	assign length        = length_q;
	assign last_of_run   = last_q;

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length above capacity");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (LEN_W'(idx_q) < len_q))
		else $error("dump index past end of list");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && dec_ins) |=> (len_q == $past(len_q) + LEN_W'(1)))
		else $error("insert did not grow the list");

endmodule

FILE: hdl/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of signed 32-bit values with insert, delete and dump requests.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY (olid_pkg) values, front at index 0. A
// request adds at the end, the front or a 1-based position, deletes the
// last, the first or a 1-based position (position 0 or 1 means the front),
// or dumps the list. Inserts and deletes return one result with a status
// (ok, empty, out of bounds, full) and the new length; a dump returns one
// result per element in order, the final one flagged by last_of_run, or a
// single empty-status result on an empty list. Request type 7 is dropped
// with no result. Timing: a request is registered when taken and executed
// in the next cycle, or later while the output register still holds a
// result not yet taken. The list is a row of entry registers that all
// shift by one place in the same cycle, so the cost of an insert or
// delete does not grow with the list; a dump is paced by the single
// output register, one element per cycle while the output side takes
// them. A new request is taken as soon as the previous one has handed
// its last result to the output register, even while that result still
// waits to be taken.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete import olid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [VAL_W-1:0]  value,
	input  logic [POS_W-1:0]         position,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic signed [VAL_W-1:0]  element,
	output logic [EIDX_W-1:0]        element_index,
	output logic [OLEN_W-1:0]        length,
	output logic                     last_of_run
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: request acceptance and result pacing
	olid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// storage, decode and result register
	olid_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.value         (value),
		.position      (position),
		.status        (status),
		.element       (element),
		.element_index (element_index),
		.length        (length),
		.last_of_run   (last_of_run)
	);

endmodule
